// ----- hw/rtl/frl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package frl_pkg;

	// Default number of fraction bits of the vector components.
	localparam int VEC_FRAC_BITS_DEF = 14;

	// One in Q1.15.
	localparam logic [15:0] Q15_ONE = 16'd32768;

	// Number of result bits produced by the square root and the dividers.
	localparam int ROOT_BITS = 16;
	localparam int QUO_BITS  = 16;

	// Job handed from the front end to the back end through the queue.
	typedef struct packed {
		logic [15:0] cos1;
		logic [15:0] cos2;
		logic [15:0] n1;
		logic [15:0] n2;
		logic        cos_clamped;
		logic        total_internal;
	} frl_job_t;

endpackage
`default_nettype wire

// ----- hw/rtl/frl_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Hit channel: one ray-surface hit per transaction.
interface frl_hit_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [15:0] dir_z;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic        [15:0] sin2_sq;
	logic        [15:0] index_in;
	logic        [15:0] index_out;

	modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,
		sin2_sq, index_in, index_out, input ready);
	modport sink (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,
		sin2_sq, index_in, index_out, output ready);
endinterface

// Result channel: one reflectance per transaction.
interface frl_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] reflectance;
	logic        cos_clamped;
	logic        total_internal;

	modport source (output valid, reflectance, cos_clamped, total_internal,
		input ready);
	modport sink (input valid, reflectance, cos_clamped, total_internal,
		output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/frl_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module frl_front import frl_pkg::*; #(
	parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	frl_hit_if.sink       hit,
	output logic          job_valid,
	input  wire logic     job_ready,
	output frl_job_t      job
);

	localparam int SH = 2 * VEC_FRAC_BITS - 15;
	localparam int MW = (2 * VEC_FRAC_BITS + 1 > 34) ? 2 * VEC_FRAC_BITS + 1 : 34;
	localparam logic [MW-1:0] DOT_ONE = MW'(1) << (2 * VEC_FRAC_BITS);

	logic en;

	// Stage 1: component products and sine saturation.
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic        [15:0] s2_s1, n1_s1, n2_s1;
	logic               tir_s1, v_s1;

	// Stage 2 combinational terms: dot product and its magnitude.
	logic signed [33:0] dot_c;
	logic        [33:0] mag_c;
	logic      [MW-1:0] mag_ext_c;

	// Square root stages, one result bit each; index 0 is stage 2, which holds
	// cos1, the flags and the radicand.
	logic [31:0] sq_rem_s  [0:ROOT_BITS];
	logic [15:0] sq_root_s [0:ROOT_BITS];
	frl_job_t    sq_job_s  [0:ROOT_BITS];
	logic        sq_v_s    [0:ROOT_BITS];
	logic [31:0] sq_inc_c  [0:ROOT_BITS-1];
	logic        sq_take_c [0:ROOT_BITS-1];

	// The whole chain moves whenever its last stage can empty.
	assign en        = !sq_v_s[ROOT_BITS] || job_ready;
	assign hit.ready = en;

	always_comb begin
		dot_c     = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
		mag_c     = dot_c[33] ? 34'(-dot_c) : 34'(dot_c);
		mag_ext_c = MW'(mag_c);
	end

	// Trial increment (root + 2^b)^2 - root^2 for each result bit.
	always_comb begin
		for (int k = 0; k < ROOT_BITS; k++) begin
			sq_inc_c[k]  = (32'(sq_root_s[k]) << (ROOT_BITS - k))
				+ (32'd1 << (2 * (ROOT_BITS - 1 - k)));
			sq_take_c[k] = sq_rem_s[k] >= sq_inc_c[k];
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= ROOT_BITS; k++) sq_v_s[k] <= 1'b0;
		end else if (en) begin
			v_s1      <= hit.valid;
			sq_v_s[0] <= v_s1;
			for (int k = 1; k <= ROOT_BITS; k++) sq_v_s[k] <= sq_v_s[k-1];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= 32'(hit.dir_x) * 32'(hit.norm_x);
			py_s1  <= 32'(hit.dir_y) * 32'(hit.norm_y);
			pz_s1  <= 32'(hit.dir_z) * 32'(hit.norm_z);
			tir_s1 <= hit.sin2_sq > Q15_ONE;
			s2_s1  <= (hit.sin2_sq > Q15_ONE) ? Q15_ONE : hit.sin2_sq;
			n1_s1  <= hit.index_in;
			n2_s1  <= hit.index_out;

			// Stage 2 feeds the first root step.
			sq_job_s[0].cos_clamped    <= mag_ext_c > DOT_ONE;
			sq_job_s[0].cos1           <= (mag_ext_c > DOT_ONE) ? Q15_ONE
				: 16'(mag_ext_c >> SH);
			sq_job_s[0].cos2           <= '0;
			sq_job_s[0].total_internal <= tir_s1;
			sq_job_s[0].n1             <= n1_s1;
			sq_job_s[0].n2             <= n2_s1;
			sq_rem_s[0]                <= 32'(Q15_ONE - s2_s1) << 15;
			sq_root_s[0]               <= '0;

			for (int k = 0; k < ROOT_BITS; k++) begin
				sq_rem_s[k+1]  <= sq_take_c[k] ? sq_rem_s[k] - sq_inc_c[k] : sq_rem_s[k];
				sq_root_s[k+1] <= sq_take_c[k]
					? (sq_root_s[k] | (16'd1 << (ROOT_BITS - 1 - k))) : sq_root_s[k];
				sq_job_s[k+1]  <= sq_job_s[k];
			end
		end
	end

	always_comb begin
		job      = sq_job_s[ROOT_BITS];
		job.cos2 = sq_root_s[ROOT_BITS];
	end
	assign job_valid = sq_v_s[ROOT_BITS];

	// A saturated cosine is exactly one.
	a_clamp_one: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job.cos_clamped |-> job.cos1 == Q15_ONE)
		else $error("clamped cos1 is not one");

	// Total internal reflection leaves no transmitted cosine.
	a_tir_zero: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job.total_internal |-> job.cos2 == 16'd0)
		else $error("cos2 not zero under total internal reflection");

endmodule
`default_nettype wire

// ----- hw/rtl/frl_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module frl_queue import frl_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_valid,
	output logic           push_ready,
	input  wire frl_job_t  push_job,
	output logic           pop_valid,
	input  wire logic      pop_ready,
	output frl_job_t       pop_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	frl_job_t        mem_q [0:DEPTH-1];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     count_q;
	logic            push, pop;

	assign push_ready = count_q != (AW+1)'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("queue fill count beyond depth");

endmodule
`default_nettype wire

// ----- hw/rtl/frl_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module frl_back import frl_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     job_valid,
	output logic          job_ready,
	input  wire frl_job_t job,
	frl_res_if.source     res
);

	logic en;

	// Stage 1: the four index-cosine products.
	logic [31:0] po_s1, qo_s1, pp_s1, qp_s1;
	logic        cf_s1, tf_s1, v_s1;

	// Divider stages per ratio (0 orthogonal, 1 parallel); index 0 is stage 2.
	logic [33:0] dv_rem_s  [0:QUO_BITS][2];
	logic [32:0] dv_den_s  [0:QUO_BITS][2];
	logic [15:0] dv_quo_s  [0:QUO_BITS][2];
	logic        dv_zero_s [0:QUO_BITS][2];
	logic        dv_cf_s   [0:QUO_BITS];
	logic        dv_tf_s   [0:QUO_BITS];
	logic        dv_v_s    [0:QUO_BITS];
	logic [33:0] dv_try_c  [0:QUO_BITS-1][2];

	// Squares and final sum.
	logic [31:0] o2_s3, p2_s3;
	logic        cf_s3, tf_s3, v_s3;
	logic [15:0] kr_q;
	logic        cf_q, tf_q, v_q;

	assign en        = !v_q || res.ready;
	assign job_ready = en;

	// Shift in the next dividend bit; the first step compares unshifted.
	always_comb begin
		for (int k = 0; k < QUO_BITS; k++) begin
			for (int r = 0; r < 2; r++) begin
				dv_try_c[k][r] = (k == 0) ? dv_rem_s[k][r] : dv_rem_s[k][r] << 1;
			end
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= QUO_BITS; k++) dv_v_s[k] <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else if (en) begin
			v_s1      <= job_valid;
			dv_v_s[0] <= v_s1;
			for (int k = 1; k <= QUO_BITS; k++) dv_v_s[k] <= dv_v_s[k-1];
			v_s3 <= dv_v_s[QUO_BITS];
			v_q  <= v_s3;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			po_s1 <= {16'd0, job.n2} * {16'd0, job.cos1};
			qo_s1 <= {16'd0, job.n1} * {16'd0, job.cos2};
			pp_s1 <= {16'd0, job.n2} * {16'd0, job.cos2};
			qp_s1 <= {16'd0, job.n1} * {16'd0, job.cos1};
			cf_s1 <= job.cos_clamped;
			tf_s1 <= job.total_internal;

			// Numerator magnitude and denominator of each ratio.
			dv_rem_s[0][0]  <= 34'((po_s1 >= qo_s1) ? po_s1 - qo_s1 : qo_s1 - po_s1);
			dv_den_s[0][0]  <= 33'(po_s1) + 33'(qo_s1);
			dv_zero_s[0][0] <= (po_s1 == 32'd0) && (qo_s1 == 32'd0);
			dv_rem_s[0][1]  <= 34'((pp_s1 >= qp_s1) ? pp_s1 - qp_s1 : qp_s1 - pp_s1);
			dv_den_s[0][1]  <= 33'(pp_s1) + 33'(qp_s1);
			dv_zero_s[0][1] <= (pp_s1 == 32'd0) && (qp_s1 == 32'd0);
			dv_quo_s[0][0]  <= '0;
			dv_quo_s[0][1]  <= '0;
			dv_cf_s[0]      <= cf_s1;
			dv_tf_s[0]      <= tf_s1;

			// Restoring division, one quotient bit per stage.
			for (int k = 0; k < QUO_BITS; k++) begin
				for (int r = 0; r < 2; r++) begin
					if (dv_try_c[k][r] >= 34'(dv_den_s[k][r])) begin
						dv_rem_s[k+1][r] <= dv_try_c[k][r] - 34'(dv_den_s[k][r]);
						dv_quo_s[k+1][r] <= {dv_quo_s[k][r][14:0], 1'b1};
					end else begin
						dv_rem_s[k+1][r] <= dv_try_c[k][r];
						dv_quo_s[k+1][r] <= {dv_quo_s[k][r][14:0], 1'b0};
					end
					dv_den_s[k+1][r]  <= dv_den_s[k][r];
					dv_zero_s[k+1][r] <= dv_zero_s[k][r];
				end
				dv_cf_s[k+1] <= dv_cf_s[k];
				dv_tf_s[k+1] <= dv_tf_s[k];
			end

			// Squares of the ratios; a zero denominator gives a zero ratio.
			o2_s3 <= dv_zero_s[QUO_BITS][0] ? 32'd0
				: {16'd0, dv_quo_s[QUO_BITS][0]} * {16'd0, dv_quo_s[QUO_BITS][0]};
			p2_s3 <= dv_zero_s[QUO_BITS][1] ? 32'd0
				: {16'd0, dv_quo_s[QUO_BITS][1]} * {16'd0, dv_quo_s[QUO_BITS][1]};
			cf_s3 <= dv_cf_s[QUO_BITS];
			tf_s3 <= dv_tf_s[QUO_BITS];

			// Mean of the squares, back to Q1.15.
			kr_q <= 16'((33'(o2_s3) + 33'(p2_s3)) >> 16);
			cf_q <= cf_s3;
			tf_q <= tf_s3;
		end
	end

	assign res.valid          = v_q;
	assign res.reflectance    = kr_q;
	assign res.cos_clamped    = cf_q;
	assign res.total_internal = tf_q;

	a_kr_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.reflectance <= Q15_ONE)
		else $error("reflectance above one");

endmodule
`default_nettype wire

// ----- hw/rtl/fresnel_reflectance_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Unpolarised Fresnel reflectance for a stream of ray-surface hits.
// The hit channel carries an incident direction and a surface normal (signed,
// VEC_FRAC_BITS fraction bits), the squared sine of the transmitted angle in
// Q1.15 and the two refractive indices in Q4.12. The result channel returns
// the reflectance in Q1.15 with flags for a saturated cosine and for total
// internal reflection. Each hit gives exactly one result, in order.
// One hit is accepted every cycle while hit.ready is high. A hit passes through
// the front end (dot product and a 16-step pipelined square root), the job
// queue and the back end (products, two 16-step pipelined dividers, squares,
// output register).
// Reset clears only the pipeline valid bits and the queue pointers and count;
// the block holds no state between hits. When the receiver stalls, the back
// end holds and the queue of four jobs fills while the front end keeps
// accepting; once it is full and a job waits at the front end, hit.ready falls.
module fresnel_reflectance_unit import frl_pkg::*; #(
	parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	frl_hit_if.sink   hit,
	frl_res_if.source res
);

	logic     fj_valid, fj_ready, bj_valid, bj_ready;
	frl_job_t fj, bj;

	// Front end: cosines and flags.
	frl_front #(.VEC_FRAC_BITS(VEC_FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hit       (hit),
		.job_valid (fj_valid),
		.job_ready (fj_ready),
		.job       (fj)
	);

	// Job queue between the two ends.
	frl_queue #(.DEPTH(4)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fj_valid),
		.push_ready (fj_ready),
		.push_job   (fj),
		.pop_valid  (bj_valid),
		.pop_ready  (bj_ready),
		.pop_job    (bj)
	);

	// Back end: ratios and reflectance.
	frl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bj_valid),
		.job_ready (bj_ready),
		.job       (bj),
		.res       (res)
	);

endmodule
`default_nettype wire
